>>> sv/leb_pkg.sv
// Shared types, constants and helpers for the LEB128 encoder.
package leb_pkg;

  localparam int ValueW   = 64;
  localparam int DigitW   = 7;
  localparam int MaxBytes = 10;
  localparam int CountW   = $clog2(MaxBytes + 1);

  localparam logic [7:0] CONT_BIT   = 8'h80;
  localparam logic [6:0] DIGIT_MASK = 7'h7f;
  localparam logic [6:0] SIGN_BIT   = 7'h40;

  typedef enum logic [1:0] {
    CMD_UNSIGNED = 2'd0,
    CMD_SIGNED   = 2'd1,
    CMD_PADDED   = 2'd2
  } cmd_t;

  // Byte count for padded mode: ceil(pad/7), at least one, capped at MaxBytes.
  function automatic logic [CountW-1:0] pad_byte_count(input logic [6:0] pad);
    logic [CountW-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < MaxBytes; k++) begin
      if (pad > 7'(DigitW * k)) begin
        cnt = cnt + CountW'(1);
      end
    end
    if (cnt == '0) begin
      cnt = CountW'(1);
    end
    return cnt;
  endfunction

endpackage

>>> sv/leb128_encoder.sv
// LEB128 encoder top level: serializes a value to code bytes, one 7-bit digit per cycle unless stalled.
//
// Input channel (in_valid/in_stall): command, 64-bit value and pad_bits.
// in_command 0 = unsigned minimal, 1 = signed minimal, 2 = padded unsigned
// with ceil(pad_bits/7) bytes (at least 1, at most 10). Command 3 is
// accepted and produces nothing.
// Output channel (out_valid/out_stall): one code byte per transaction,
// least significant digit first, bit 7 set on all but the final byte,
// out_last high on the final byte.
// The value sits in a shift register that drops one 7-bit digit per
// emitted byte, and each byte is registered in the output register.
// A new transaction is taken only once the shift register has emitted
// the final byte of the previous value.
// in_stall is high while a value is being serialized.
// When the receiver stalls, the output register holds its byte and the
// shift register waits; nothing is dropped.
// Reset (rst_n low, synchronous) empties the output register and abandons
// any value in progress.
module leb128_encoder
  import leb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_value,
  input  logic [6:0]  in_pad_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_code_byte,
  output logic        out_last
);

  logic              busy_r, busy_nxt;
  cmd_t              mode_r;
  logic [ValueW-1:0] value_r, value_nxt;
  logic [CountW-1:0] left_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_code_byte_r;
  logic              out_last_r;

  logic              in_take;
  logic              out_free;
  logic              step;
  logic [6:0]        digit;
  logic [ValueW-1:0] shift_u, shift_s;
  logic              more;

  assign in_stall = busy_r;
  assign in_take  = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign step     = busy_r && out_free;

  assign digit   = value_r[DigitW-1:0] & DIGIT_MASK;
  assign shift_u = value_r >> DigitW;
  assign shift_s = {{DigitW{value_r[ValueW-1]}}, value_r[ValueW-1:DigitW]};

  always_comb begin
    more      = 1'b0;
    value_nxt = shift_u;
    case (mode_r)
      CMD_UNSIGNED: begin
        more = (shift_u != '0);
      end
      CMD_SIGNED: begin
        value_nxt = shift_s;
        more = !(((shift_s == '0) && ((digit & SIGN_BIT) == '0)) ||
                 ((shift_s == '1) && ((digit & SIGN_BIT) != '0)));
      end
      CMD_PADDED: begin
        more = (left_r != CountW'(1));
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = more;
    end else if (in_take) begin
      // unused command code: accepted, no bytes
      busy_nxt = (in_command == CMD_UNSIGNED) || (in_command == CMD_SIGNED) ||
                 (in_command == CMD_PADDED);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r  <= cmd_t'(in_command);
      value_r <= in_value;
      left_r  <= pad_byte_count(in_pad_bits);
    end else if (step) begin
      value_r <= value_nxt;
      left_r  <= left_r - CountW'(1);
    end
    if (step) begin
      out_code_byte_r <= {1'b0, digit} | (more ? CONT_BIT : 8'h00);
      out_last_r      <= !more;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_byte = out_code_byte_r;
  assign out_last      = out_last_r;

endmodule

>>> test/tb_leb128_encoder.sv
// Self-checking testbench for leb128_encoder: directed and random values in all modes.
module tb_leb128_encoder
  import leb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NONE = 2'd3;   // command code with no encoding
  localparam int HangLimit = 1000;          // cycles with no transaction before giving up
  localparam int DrainCycles = 30;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } leb_byte_t;

  class leb_scoreboard;
    leb_byte_t  byte_q[$];
    int unsigned errors = 0;

    function void push_byte(logic [6:0] digit, logic more);
      leb_byte_t b;
      b.code = {more, digit};
      b.last = !more;
      byte_q.push_back(b);
    endfunction

    // Works out the byte sequence of one accepted input transaction.
    function void note_input(logic [1:0] cmd, logic [63:0] val, logic [6:0] pad);
      logic [63:0] rest;
      logic [6:0]  digit;
      logic        more;
      int          count;
      int          n;
      rest = val;
      n = 0;
      case (cmd)
        CMD_UNSIGNED: begin
          more = 1'b1;
          while (more && n < MaxBytes) begin
            digit = rest[6:0];
            rest = rest >> DigitW;
            more = (rest != '0);
            push_byte(digit, more);
            n++;
          end
        end
        CMD_SIGNED: begin
          more = 1'b1;
          while (more && n < MaxBytes) begin
            digit = rest[6:0];
            rest = {{7{rest[63]}}, rest[63:7]};
            // done once the remainder is pure sign and bit 6 agrees with it
            more = !((rest == '0 && !digit[6]) || (&rest && digit[6]));
            push_byte(digit, more);
            n++;
          end
        end
        CMD_PADDED: begin
          count = (pad > 7'd64) ? 64 : int'(pad);
          count = (count + 6) / 7;
          if (count < 1) begin
            count = 1;
          end
          for (int i = 0; i < count; i++) begin
            digit = rest[6:0];
            rest = rest >> DigitW;
            push_byte(digit, i != count - 1);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [7:0] code, logic last);
      leb_byte_t exp_b;
      if (byte_q.size() == 0) begin
        $error("unexpected code_byte 0x%02h last %0b", code, last);
        errors++;
        return;
      end
      exp_b = byte_q.pop_front();
      if (code !== exp_b.code) begin
        $error("code_byte: expected 0x%02h, got 0x%02h", exp_b.code, code);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("last: expected %0b, got %0b", exp_b.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return byte_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [63:0] in_value = '0;
  logic [6:0]  in_pad_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_code_byte;
  logic        out_last;

  logic        calm = 1'b0;   // both sides run flat out while set
  int          hang_cycles = 0;
  leb_scoreboard sb = new();

  leb128_encoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_value     (in_value),
    .in_pad_bits  (in_pad_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_code_byte(out_code_byte),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Result side: check each accepted byte, stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_code_byte, out_last);
    end
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HangLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [63:0] val, input logic [6:0] pad);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value    <= val;
    in_pad_bits <= pad;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_input(cmd, val, pad);
  endtask

  // Random value of random significant length, so all byte counts show up.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    w = $urandom_range(64);
    if (w < 64) begin
      v = v & ((64'd1 << w) - 64'd1);
    end
    if ($urandom_range(1) == 1) begin
      v = ~v;
    end
    return v;
  endfunction

  initial begin
    logic [1:0]  cmd;
    logic [6:0]  pad;
    int          r;
    int          counted;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, sign boundaries, padding corners, unused command
    send(CMD_UNSIGNED, 64'd0, 7'd0);
    send(CMD_UNSIGNED, 64'd127, 7'h7f);
    send(CMD_UNSIGNED, 64'd128, 7'd5);
    send(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    send(CMD_UNSIGNED, 64'h8000_0000_0000_0000, 7'd64);
    send(CMD_SIGNED, 64'd0, 7'd0);
    send(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7f);
    send(CMD_SIGNED, 64'd63, 7'd3);
    send(CMD_SIGNED, 64'd64, 7'd3);
    send(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFC0, 7'd9);
    send(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFBF, 7'd9);
    send(CMD_SIGNED, 64'h8000_0000_0000_0000, 7'd1);
    send(CMD_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 7'd1);
    send(CMD_PADDED, 64'h0000_0000_0000_005A, 7'd0);
    send(CMD_PADDED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    send(CMD_PADDED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1);
    send(CMD_PADDED, 64'h0000_0000_0000_3FFF, 7'd7);
    send(CMD_PADDED, 64'h0000_0000_0000_3FFF, 7'd8);
    send(CMD_PADDED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
    send(CMD_PADDED, 64'h0123_4567_89AB_CDEF, 7'd65);
    send(CMD_PADDED, 64'hFEDC_BA98_7654_3210, 7'h7f);
    send(CMD_PADDED, 64'h0000_0000_0000_0001, 7'd63);
    send(CMD_NONE, 64'hA5A5_5A5A_0F0F_F0F0, 7'h7f);
    send(CMD_UNSIGNED, 64'd300, 7'd0);

    // random: unused commands are mixed in but not counted
    counted = 0;
    while (counted < 70) begin
      calm <= (counted >= 25 && counted < 50);
      r = $urandom_range(99);
      if (r < 8) begin
        cmd = CMD_NONE;
      end else begin
        cmd = 2'($urandom_range(2));
        counted++;
      end
      r = $urandom_range(99);
      if (r < 10) begin
        pad = 7'($urandom_range(127, 65));
      end else if (r < 15) begin
        pad = 7'd0;
      end else begin
        pad = 7'($urandom_range(64, 1));
      end
      if (cmd != CMD_PADDED && $urandom_range(1) == 1) begin
        pad = 7'($urandom_range(127));
      end
      send(cmd, rand_value(), pad);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d code bytes never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> leb128_encoder.f
sv/leb_pkg.sv
sv/leb128_encoder.sv
test/tb_leb128_encoder.sv
